@@ src/ccd_pkg.sv @@
// shared constants and types of the charge deposition unit
package ccd_pkg;

	localparam int GRID_CELLS_X = 64;
	localparam int GRID_CELLS_Y = 64;
	localparam int NODES_X      = GRID_CELLS_X + 1;
	localparam int NODES_Y      = GRID_CELLS_Y + 1;
	localparam int NODES        = NODES_X * NODES_Y;
	localparam int ADDR_W       = $clog2(NODES);

	localparam int CELL_W = 7;
	localparam int FRAC_W = 16;
	localparam int CW_W   = 32;
	localparam int ACC_W  = 40;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = CW_W + 1;
	localparam int MUL_B_W = FRAC_W + 2;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic signed [CW_W-1:0] CW_RESET = 32'sd65536;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic MODE_DEPOSIT = 1'b0;
	localparam logic MODE_READ    = 1'b1;

	// one access to the single-port grid memory
	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [ACC_W-1:0]  wdata;
	} mem_req_t;

endpackage

@@ src/ccd_mul.sv @@
// shared signed multiplier with registered product
module ccd_mul import ccd_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p
);

	logic signed [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

	assign p = p_q;

endmodule

@@ src/ccd_grid_ram.sv @@
// single-port density grid memory with registered read data
module ccd_grid_ram import ccd_pkg::*; (
	input  logic             clk,
	input  mem_req_t         req,
	output logic [ACC_W-1:0] rdata
);

	logic [ACC_W-1:0] mem [NODES];
	logic [ACC_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata_q <= mem[req.addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/cic_charge_deposition_unit.sv @@
// top level: sequencer, accumulator and ports of the charge deposition unit
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tdata cell_x, cell_y, frac_x, frac_y; tuser mode
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata density
//  cfg      in   cfg_we                         cfg_wdata charge_weight
//
// a deposit runs from its transfer through, for each of the four nodes, a weight multiply,
// a charge multiply on the same shared multiplier, and a read-modify-write on the single-port
// grid memory; an out-of-range deposit is dropped at its transfer. a read fetches its node and
// then waits for the output register to drain. after reset a clearing pass over all 4225 nodes
// zeroes the grid, with s_axis_tready low. a waiting result does not block deposits.
module cic_charge_deposition_unit import ccd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // cell_x, cell_y, frac_x, frac_y, zero pad
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // density
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_WGT   = 7'b0000100,
		S_CHG   = 7'b0001000,
		S_ACC   = 7'b0010000,
		S_RD    = 7'b0100000,
		S_RDO   = 7'b1000000
	} state_t;

	state_t state_q;

	logic signed [CW_W-1:0] charge_weight_q;
	logic [ADDR_W-1:0]      clr_q;
	logic [1:0]             node_q;
	logic [CELL_W-1:0]      cx_q;
	logic [CELL_W-1:0]      cy_q;
	logic [FRAC_W-1:0]      fx_q;
	logic [FRAC_W-1:0]      fy_q;
	logic                   rd_oor_q;
	logic                   out_valid_q;
	logic [ACC_W-1:0]       out_data_q;

	logic              mode;
	logic [CELL_W-1:0] in_cx;
	logic [CELL_W-1:0] in_cy;
	logic [FRAC_W-1:0] in_fx;
	logic [FRAC_W-1:0] in_fy;
	logic              s_fire;
	logic              dep_ok;
	logic              rd_ok;
	logic              rdo_fire;

	assign mode  = s_axis_tuser;
	assign in_cx = s_axis_tdata[6:0];
	assign in_cy = s_axis_tdata[13:7];
	assign in_fx = s_axis_tdata[29:14];
	assign in_fy = s_axis_tdata[45:30];

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign dep_ok = (int'(in_cx) < GRID_CELLS_X) && (int'(in_cy) < GRID_CELLS_Y);
	assign rd_ok  = (int'(in_cx) <= GRID_CELLS_X) && (int'(in_cy) <= GRID_CELLS_Y);
	assign rdo_fire = (state_q == S_RDO) && (!out_valid_q || m_axis_tready);

	// node address: bit 0 of node_q steps in x, bit 1 steps in y
	localparam logic [ADDR_W-1:0] NODES_X_A = ADDR_W'(NODES_X);
	logic [ADDR_W-1:0] row;
	logic [ADDR_W-1:0] col;
	logic [ADDR_W-1:0] node_addr;

	assign row       = ADDR_W'(cy_q) + ADDR_W'(node_q[1]);
	assign col       = ADDR_W'(cx_q) + ADDR_W'(node_q[0]);
	assign node_addr = row * NODES_X_A + col;

	// weights for the current node
	logic [FRAC_W:0] wx;
	logic [FRAC_W:0] wy;

	assign wx = node_q[0] ? {1'b0, fx_q} : (17'h10000 - {1'b0, fx_q});
	assign wy = node_q[1] ? {1'b0, fy_q} : (17'h10000 - {1'b0, fy_q});

	// shared multiplier
	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic signed [MUL_P_W-1:0] p_round;
	logic [FRAC_W:0]           w_node;
	logic signed [MUL_P_W-17:0] contrib;

	assign p_round = mul_p + MUL_P_W'(32768);
	assign w_node  = p_round[32:16];
	// floor of the rounded charge product over 2^16
	assign contrib = p_round[MUL_P_W-1:16];

	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_WGT: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(wx);
				mul_b  = MUL_B_W'(wy);
			end
			S_CHG: begin
				mul_en = 1'b1;
				mul_a  = {charge_weight_q[CW_W-1], charge_weight_q};
				mul_b  = MUL_B_W'(w_node);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	ccd_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// saturating accumulate
	logic [ACC_W-1:0]       rdata;
	logic signed [ACC_W:0]  sum;
	logic [ACC_W-1:0]       sum_sat;

	assign sum = $signed({rdata[ACC_W-1], rdata})
		+ $signed({{(ACC_W + 1 - $bits(contrib)){contrib[$bits(contrib)-1]}}, contrib});

	always_comb begin
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sum_sat = sum[ACC_W-1:0];
		end
	end

	// memory port
	mem_req_t mem_req;

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_CLEAR: begin
				mem_req.en   = 1'b1;
				mem_req.we   = 1'b1;
				mem_req.addr = clr_q;
			end
			S_WGT: begin
				mem_req.en   = 1'b1;
				mem_req.addr = node_addr;
			end
			S_ACC: begin
				mem_req.en    = 1'b1;
				mem_req.we    = 1'b1;
				mem_req.addr  = node_addr;
				mem_req.wdata = sum_sat;
			end
			S_RD: begin
				mem_req.en   = !rd_oor_q;
				mem_req.addr = node_addr;
			end
			S_RDO: begin
				mem_req.en   = rdo_fire && !rd_oor_q;
				mem_req.we   = 1'b1;
				mem_req.addr = node_addr;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	ccd_grid_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			node_q   <= '0;
			rd_oor_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					node_q <= '0;
					if (s_fire) begin
						if (mode == MODE_READ) begin
							rd_oor_q <= !rd_ok;
							state_q  <= S_RD;
						end else if (dep_ok) begin
							state_q <= S_WGT;
						end
					end
				end
				S_WGT: begin
					state_q <= S_CHG;
				end
				S_CHG: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					node_q <= node_q + 1'b1;
					state_q <= (node_q == 2'd3) ? S_IDLE : S_WGT;
				end
				S_RD: begin
					state_q <= S_RDO;
				end
				S_RDO: begin
					if (rdo_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cx_q <= in_cx;
			cy_q <= in_cy;
			fx_q <= in_fx;
			fy_q <= in_fy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_weight_q <= CW_RESET;
		end else if (cfg_we) begin
			charge_weight_q <= cfg_wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdo_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdo_fire) begin
			out_data_q <= rd_oor_q ? '0 : rdata;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// checks
	a_no_write_on_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WGT || state_q == S_RD) |-> !mem_req.we)
		else $error("grid written during a node fetch");

	a_deposit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && mode == MODE_DEPOSIT && dep_ok) |=> (state_q == S_WGT && node_q == 2'd0))
		else $error("deposit did not start at the first node");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_RDO)
		else $error("result raised outside a read");

	a_idle_node_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC && node_q == 2'd3) |=> state_q == S_IDLE)
		else $error("deposit did not finish after the fourth node");

endmodule

@@ dv/tb_top.sv @@
// testbench for the cloud-in-cell charge deposition unit: directed table, then random phases
`timescale 1ns / 1ps

module tb_top import ccd_pkg::*;;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PLAN_ROWS     = 25;
	localparam int PHASES        = 6;
	localparam int HOT_ITEMS     = 330;
	localparam int MIX_ITEMS     = 110;

	localparam longint DENS_HI = ACC_MAX;
	localparam longint DENS_LO = ACC_MIN;

	typedef struct packed {
		logic              mode;
		logic [CELL_W-1:0] cx;
		logic [CELL_W-1:0] cy;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
	} item_t;

	typedef struct packed {
		item_t            it;
		logic             typed;
		logic [ACC_W-1:0] known;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // cell_x, cell_y, frac_x, frac_y, zero pad
	logic        s_axis_tuser;   // mode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // density
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	// shadow grid and weight
	longint           node_density [NODES];
	longint           charge_w;
	logic [ACC_W-1:0] density_expected [$];
	logic [ACC_W-1:0] want;

	bit  calm;
	int  stall_left;
	int  errors;
	int  cycle_count;
	int  n_deposits, n_ignored, n_reads, n_checked, n_clamped, n_settings;

	cic_charge_deposition_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// bilinear share of the charge onto one node, saturating
	function automatic void add_charge(int nx, int ny, longint wa, longint wb);
		longint w;
		longint c;
		longint s;
		int     idx;
		w = (wa * wb + 32768) >>> 16;
		c = (charge_w * w + 32768) >>> 16;
		idx = ny * NODES_X + nx;
		s = node_density[idx] + c;
		if (s > DENS_HI) begin
			s = DENS_HI;
			n_clamped++;
		end else if (s < DENS_LO) begin
			s = DENS_LO;
			n_clamped++;
		end
		node_density[idx] = s;
	endfunction

	function automatic item_t random_item(bit hot);
		item_t it;
		int    r;
		it.fx = FRAC_W'($urandom_range(0, 65535));
		it.fy = FRAC_W'($urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		if (hot) begin
			if (r < 3) begin
				it.mode = MODE_READ;
				it.cx = CELL_W'($urandom_range(0, 2));
				it.cy = CELL_W'(2);
			end else begin
				it.mode = MODE_DEPOSIT;
				it.cx = CELL_W'($urandom_range(0, 1));
				it.cy = CELL_W'($urandom_range(0, 1));
				if (r >= 10) begin
					// push nearly all of the charge onto node (1,1) so it saturates
					it.fx = it.cx ? FRAC_W'($urandom_range(0, 4095))
						: FRAC_W'($urandom_range(61440, 65535));
					it.fy = it.cy ? FRAC_W'($urandom_range(0, 4095))
						: FRAC_W'($urandom_range(61440, 65535));
				end
			end
		end else if (r < 55) begin
			it.mode = MODE_DEPOSIT;
			if ($urandom_range(0, 1)) begin
				it.cx = CELL_W'($urandom_range(30, 33));
				it.cy = CELL_W'($urandom_range(30, 33));
			end else begin
				it.cx = CELL_W'($urandom_range(0, GRID_CELLS_X - 1));
				it.cy = CELL_W'($urandom_range(0, GRID_CELLS_Y - 1));
			end
		end else if (r < 62) begin
			it.mode = MODE_DEPOSIT;
			if ($urandom_range(0, 1)) begin
				it.cx = CELL_W'($urandom_range(GRID_CELLS_X, 127));
				it.cy = CELL_W'($urandom_range(0, 127));
			end else begin
				it.cx = CELL_W'($urandom_range(0, 127));
				it.cy = CELL_W'($urandom_range(GRID_CELLS_Y, 127));
			end
		end else if (r < 92) begin
			it.mode = MODE_READ;
			if ($urandom_range(0, 1)) begin
				it.cx = CELL_W'($urandom_range(30, 34));
				it.cy = CELL_W'($urandom_range(30, 34));
			end else begin
				it.cx = CELL_W'($urandom_range(0, GRID_CELLS_X));
				it.cy = CELL_W'($urandom_range(0, GRID_CELLS_Y));
			end
		end else begin
			it.mode = MODE_READ;
			if ($urandom_range(0, 1)) begin
				it.cx = CELL_W'($urandom_range(GRID_CELLS_X + 1, 127));
				it.cy = CELL_W'($urandom_range(0, 127));
			end else begin
				it.cx = CELL_W'($urandom_range(0, 127));
				it.cy = CELL_W'($urandom_range(GRID_CELLS_Y + 1, 127));
			end
		end
		return it;
	endfunction

	// drive one item, wait for its transfer, then update the shadow grid
	task automatic push_item(input item_t it, input bit typed, input logic [ACC_W-1:0] known);
		int               gap;
		int               idx;
		logic [ACC_W-1:0] val;
		longint           fx;
		longint           fy;
		gap = (calm || $urandom_range(0, 1)) ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.mode;
		s_axis_tdata  <= {2'b00, it.fy, it.fx, it.cy, it.cx};
		do @(posedge clk); while (!s_axis_tready);
		fx = it.fx;
		fy = it.fy;
		if (it.mode == MODE_DEPOSIT) begin
			if (it.cx < GRID_CELLS_X && it.cy < GRID_CELLS_Y) begin
				add_charge(it.cx,     it.cy,     65536 - fx, 65536 - fy);
				add_charge(it.cx + 1, it.cy,     fx,         65536 - fy);
				add_charge(it.cx,     it.cy + 1, 65536 - fx, fy);
				add_charge(it.cx + 1, it.cy + 1, fx,         fy);
				n_deposits++;
			end else begin
				n_ignored++;
			end
		end else begin
			val = '0;
			if (it.cx <= GRID_CELLS_X && it.cy <= GRID_CELLS_Y) begin
				idx = it.cy * NODES_X + it.cx;
				val = node_density[idx][ACC_W-1:0];
				node_density[idx] = 0;
			end
			density_expected.push_back(typed ? known : val);
			n_reads++;
		end
	endtask

	// drain everything in flight; deposits leave no result, so also wait out their latency
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (density_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_weight(input logic signed [CW_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		charge_w = v;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// result stall pattern
	always @(negedge clk) begin
		if (calm)
			stall_left = 0;
		else if (stall_left == 0 && $urandom_range(0, 3) == 0)
			stall_left = pick_gap();
		m_axis_tready <= (stall_left == 0);
		if (stall_left > 0)
			stall_left--;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (density_expected.size() == 0) begin
				$error("unexpected density transfer: got %0d", $signed(m_axis_tdata));
				errors++;
			end else begin
				want = density_expected.pop_front();
				n_checked++;
				if (m_axis_tdata !== want) begin
					$error("density mismatch: expected %0d, got %0d",
						$signed(want), $signed(m_axis_tdata));
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, density_expected.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		row_t                   plan [PLAN_ROWS];
		logic signed [CW_W-1:0] cw_plan [PHASES];
		item_t                  drain;
		bit                     hot;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = MODE_DEPOSIT;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		calm          = 1'b0;
		stall_left    = 0;
		errors        = 0;
		cycle_count   = 0;
		charge_w      = CW_RESET;

		// weight stays at its reset value of 1.0 for the whole table
		plan = '{
			'{'{MODE_READ,    7'd0,   7'd0,   16'd0,     16'd0    }, 1'b1, 40'd0    },
			'{'{MODE_READ,    7'd64,  7'd64,  16'd0,     16'd0    }, 1'b1, 40'd0    },
			'{'{MODE_READ,    7'd127, 7'd127, 16'd65535, 16'd65535}, 1'b1, 40'd0    },
			'{'{MODE_READ,    7'd65,  7'd0,   16'd0,     16'd0    }, 1'b1, 40'd0    },
			'{'{MODE_READ,    7'd0,   7'd65,  16'd0,     16'd0    }, 1'b1, 40'd0    },
			'{'{MODE_DEPOSIT, 7'd0,   7'd0,   16'd0,     16'd0    }, 1'b0, 40'd0    },
			'{'{MODE_READ,    7'd0,   7'd0,   16'd0,     16'd0    }, 1'b1, 40'd65536},
			'{'{MODE_READ,    7'd1,   7'd0,   16'd0,     16'd0    }, 1'b1, 40'd0    },
			'{'{MODE_DEPOSIT, 7'd63,  7'd63,  16'd65535, 16'd65535}, 1'b0, 40'd0    },
			'{'{MODE_READ,    7'd63,  7'd63,  16'd0,     16'd0    }, 1'b0, 40'd0    },
			'{'{MODE_READ,    7'd64,  7'd63,  16'd0,     16'd0    }, 1'b0, 40'd0    },
			'{'{MODE_READ,    7'd63,  7'd64,  16'd0,     16'd0    }, 1'b0, 40'd0    },
			'{'{MODE_READ,    7'd64,  7'd64,  16'd0,     16'd0    }, 1'b0, 40'd0    },
			// deposits into cells past the grid edge leave the grid untouched
			'{'{MODE_DEPOSIT, 7'd64,  7'd0,   16'd0,     16'd0    }, 1'b0, 40'd0    },
			'{'{MODE_DEPOSIT, 7'd0,   7'd64,  16'd0,     16'd0    }, 1'b0, 40'd0    },
			'{'{MODE_DEPOSIT, 7'd127, 7'd127, 16'd65535, 16'd65535}, 1'b0, 40'd0    },
			'{'{MODE_READ,    7'd64,  7'd0,   16'd0,     16'd0    }, 1'b1, 40'd0    },
			'{'{MODE_READ,    7'd0,   7'd64,  16'd0,     16'd0    }, 1'b1, 40'd0    },
			'{'{MODE_DEPOSIT, 7'd10,  7'd20,  16'd32768, 16'd32768}, 1'b0, 40'd0    },
			'{'{MODE_READ,    7'd10,  7'd20,  16'd0,     16'd0    }, 1'b1, 40'd16384},
			'{'{MODE_READ,    7'd11,  7'd21,  16'd0,     16'd0    }, 1'b0, 40'd0    },
			'{'{MODE_DEPOSIT, 7'd5,   7'd5,   16'd65535, 16'd0    }, 1'b0, 40'd0    },
			'{'{MODE_READ,    7'd5,   7'd5,   16'd0,     16'd0    }, 1'b0, 40'd0    },
			'{'{MODE_READ,    7'd6,   7'd5,   16'd0,     16'd0    }, 1'b0, 40'd0    },
			'{'{MODE_DEPOSIT, 7'd7,   7'd7,   16'd0,     16'd65535}, 1'b0, 40'd0    }
		};

		cw_plan[0] = 32'sh7fff_ffff;
		cw_plan[1] = 32'sh8000_0000;
		cw_plan[2] = '0;
		cw_plan[3] = '1;
		cw_plan[4] = $urandom;
		cw_plan[5] = $urandom_range(1, 1 << 18);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < PLAN_ROWS; i++)
			push_item(plan[i].it, plan[i].typed, plan[i].known);

		// first two phases hammer one node to drive it into saturation
		for (int p = 0; p < PHASES; p++) begin
			hot = (p < 2);
			settle();
			write_weight(cw_plan[p]);
			for (int k = 0; k < (hot ? HOT_ITEMS : MIX_ITEMS); k++) begin
				calm = (k % 80) >= 60;
				push_item(random_item(hot), 1'b0, '0);
			end
			calm = 1'b0;
			if (hot) begin
				for (int x = 0; x < 3; x++) begin
					for (int y = 0; y < 3; y++) begin
						drain = '{MODE_READ, x[CELL_W-1:0], y[CELL_W-1:0], 16'd0, 16'd0};
						push_item(drain, 1'b0, '0);
					end
				end
			end
		end

		settle();

		$display("ran %0d deposits (%0d off-grid, ignored) and %0d reads over %0d weight settings",
			n_deposits, n_ignored, n_reads, n_settings + 1);
		$display("%0d density transfers checked, %0d accumulator clamps hit, %0d mismatches",
			n_checked, n_clamped, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
